>>> hw/rtl/crect_pkg.sv
// Shared constants, widths and register codes for the rectangle fill stage.
package crect_pkg;

    localparam int COORD_BITS = 12;

    localparam int COLOR_W   = 8;
    localparam int ADDR_W    = 24;
    localparam int RECT_W    = 14;
    localparam int LIMIT_W   = 13;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam int S_FIELDS_W = 2 * COORD_BITS + 3 * COLOR_W;
    localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 3 * COLOR_W + ADDR_W;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    // Signed compare width: coordinate plus sign, or rectangle sum plus carry.
    localparam int CMP_W  = (COORD_BITS + 1 > RECT_W + 1) ? COORD_BITS + 1 : RECT_W + 1;
    localparam int CLIP_W = (COORD_BITS > LIMIT_W) ? COORD_BITS : LIMIT_W;
    localparam int ADDR_CALC_W = (COORD_BITS + LIMIT_W + 1 > ADDR_W) ?
                                 COORD_BITS + LIMIT_W + 1 : ADDR_W;

    localparam logic [COLOR_W-1:0] ALPHA_OPAQUE = 8'd255;
    localparam logic [COLOR_W-1:0] ALPHA_CLEAR  = 8'd0;

    localparam logic signed [RECT_W-1:0] RESET_RECT  = '0;
    localparam logic [LIMIT_W-1:0] RESET_CLIP        = 13'd4096;
    localparam logic [LIMIT_W-1:0] RESET_SCREEN_W    = 13'd1024;
    localparam logic [CFG_DATA_W-1:0] RESET_FILL     = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RECT_X       = 3'd0,
        REG_RECT_Y       = 3'd1,
        REG_RECT_WIDTH   = 3'd2,
        REG_RECT_HEIGHT  = 3'd3,
        REG_CLIP_MAX_X   = 3'd4,
        REG_CLIP_MAX_Y   = 3'd5,
        REG_LINE_PITCH   = 3'd6,
        REG_FILL_RGBA    = 3'd7
    } cfg_index_t;

endpackage

>>> hw/rtl/clipped_rect_alpha_fill.sv
// Top level of the clipped, alpha-blended rectangle fill pixel stage.
//
// Per-pixel stage of a 2D rectangle fill. Each input beat carries one
// framebuffer pixel (column, row, current RGB); each input beat yields exactly
// one output beat with the new RGB, a write flag on m_tuser and the linear
// pixel address row * line pitch + column, wrapped to 24 bits. A pixel is
// filled when it lies inside the rectangle, inside columns 0 .. clip_max_x-1
// and rows 0 .. clip_max_y-1, and the fill alpha is nonzero. Alpha 255 writes
// the solid fill color; other alphas blend each channel as
// (old*(255-a) + fill*a) >> 8. The stage takes one beat per clock while the
// output is not stalled; each beat passes an input register, then one level
// of logic (the row-by-width multiply for the address, one 8x8 multiply
// pair per color channel) into the output register. The input register
// also advances whenever it is empty, so a stall on m_tready only blocks
// s_tready when both are full. Program the registers only while no beat is
// in flight; writes take effect on the next clock and there is no read-back.
module clipped_rect_alpha_fill
    import crect_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    // pixel_x, pixel_y, dest_red, dest_green, dest_blue (lowest bits first)
    input  logic [S_DATA_W-1:0]    s_tdata,

    output logic                   m_tvalid,
    input  logic                   m_tready,
    // out_red, out_green, out_blue, pixel_address (lowest bits first)
    output logic [M_DATA_W-1:0]    m_tdata,
    // pixel_written
    output logic                   m_tuser
);

    // Configuration registers
    logic signed [RECT_W-1:0] rect_x_reg, rect_y_reg, rect_w_reg, rect_h_reg;
    logic [LIMIT_W-1:0]       clip_x_reg, clip_y_reg, screen_w_reg;
    logic [CFG_DATA_W-1:0]    fill_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rect_x_reg   <= RESET_RECT;
            rect_y_reg   <= RESET_RECT;
            rect_w_reg   <= RESET_RECT;
            rect_h_reg   <= RESET_RECT;
            clip_x_reg   <= RESET_CLIP;
            clip_y_reg   <= RESET_CLIP;
            screen_w_reg <= RESET_SCREEN_W;
            fill_reg     <= RESET_FILL;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                REG_RECT_X:       rect_x_reg   <= signed'(cfg_wdata[RECT_W-1:0]);
                REG_RECT_Y:       rect_y_reg   <= signed'(cfg_wdata[RECT_W-1:0]);
                REG_RECT_WIDTH:   rect_w_reg   <= signed'(cfg_wdata[RECT_W-1:0]);
                REG_RECT_HEIGHT:  rect_h_reg   <= signed'(cfg_wdata[RECT_W-1:0]);
                REG_CLIP_MAX_X:   clip_x_reg   <= cfg_wdata[LIMIT_W-1:0];
                REG_CLIP_MAX_Y:   clip_y_reg   <= cfg_wdata[LIMIT_W-1:0];
                REG_LINE_PITCH:   screen_w_reg <= cfg_wdata[LIMIT_W-1:0];
                REG_FILL_RGBA:    fill_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Handshake: the output stage frees when empty or drained, the input
    // stage frees when empty or moving into the output stage.
    logic in_valid_reg, out_valid_reg;
    logic out_adv, in_adv;

    assign out_adv  = !out_valid_reg || m_tready;
    assign in_adv   = !in_valid_reg || out_adv;
    assign s_tready = in_adv;
    assign m_tvalid = out_valid_reg;

    // Input register
    logic [COORD_BITS-1:0] px_reg, py_reg;
    logic [COLOR_W-1:0]    red_reg, green_reg, blue_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_adv) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_adv && s_tvalid) begin
            px_reg    <= s_tdata[COORD_BITS-1:0];
            py_reg    <= s_tdata[2*COORD_BITS-1 -: COORD_BITS];
            red_reg   <= s_tdata[2*COORD_BITS +: COLOR_W];
            green_reg <= s_tdata[2*COORD_BITS+COLOR_W +: COLOR_W];
            blue_reg  <= s_tdata[2*COORD_BITS+2*COLOR_W +: COLOR_W];
        end
    end

    function automatic logic [COLOR_W-1:0] blend8(
        input logic [COLOR_W-1:0] old_v,
        input logic [COLOR_W-1:0] src_v,
        input logic [COLOR_W-1:0] alpha
    );
        logic [2*COLOR_W:0] acc;
        acc = (2*COLOR_W+1)'(old_v * (ALPHA_OPAQUE - alpha))
            + (2*COLOR_W+1)'(src_v * alpha);
        return acc[2*COLOR_W-1:COLOR_W];
    endfunction

    // Hit test against the rectangle and the clip window, color blend and pixel address
    logic signed [CMP_W-1:0] sx, sy, rx0, ry0, rx1, ry1;
    logic                    hit;
    logic [COLOR_W-1:0]      fill_r, fill_g, fill_b, fill_a;
    logic                    written_next;
    logic [COLOR_W-1:0]      red_next, green_next, blue_next;
    logic [ADDR_CALC_W-1:0]  addr_full;
    logic [ADDR_W-1:0]       addr_next;

    always_comb begin
        sx  = signed'(CMP_W'(px_reg));
        sy  = signed'(CMP_W'(py_reg));
        rx0 = CMP_W'(rect_x_reg);
        ry0 = CMP_W'(rect_y_reg);
        rx1 = rx0 + CMP_W'(rect_w_reg);
        ry1 = ry0 + CMP_W'(rect_h_reg);
        hit = (sx >= rx0) && (sx < rx1) && (CLIP_W'(px_reg) < CLIP_W'(clip_x_reg))
           && (sy >= ry0) && (sy < ry1) && (CLIP_W'(py_reg) < CLIP_W'(clip_y_reg));

        fill_r = fill_reg[31:24];
        fill_g = fill_reg[23:16];
        fill_b = fill_reg[15:8];
        fill_a = fill_reg[7:0];

        written_next = hit && (fill_a != ALPHA_CLEAR);
        red_next   = red_reg;
        green_next = green_reg;
        blue_next  = blue_reg;
        if (written_next) begin
            if (fill_a == ALPHA_OPAQUE) begin
                red_next   = fill_r;
                green_next = fill_g;
                blue_next  = fill_b;
            end else begin
                red_next   = blend8(red_reg, fill_r, fill_a);
                green_next = blend8(green_reg, fill_g, fill_a);
                blue_next  = blend8(blue_reg, fill_b, fill_a);
            end
        end

        addr_full = ADDR_CALC_W'(py_reg) * ADDR_CALC_W'(screen_w_reg)
                  + ADDR_CALC_W'(px_reg);
        addr_next = addr_full[ADDR_W-1:0];
    end

    // Output register
    logic [COLOR_W-1:0] out_red_reg, out_green_reg, out_blue_reg;
    logic [ADDR_W-1:0]  out_addr_reg;
    logic               out_written_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_adv) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv && in_valid_reg) begin
            out_red_reg     <= red_next;
            out_green_reg   <= green_next;
            out_blue_reg    <= blue_next;
            out_addr_reg    <= addr_next;
            out_written_reg <= written_next;
        end
    end

    assign m_tdata = M_DATA_W'({out_addr_reg, out_blue_reg, out_green_reg, out_red_reg});
    assign m_tuser = out_written_reg;

`ifndef SYNTHESIS
    // Reset empties both stages.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !in_valid_reg && !out_valid_reg)
        else $error("pipeline not empty after reset");

    // An empty input stage never refuses a beat.
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input stage empty but not ready");

    // An accepted beat occupies the input stage on the next cycle.
    a_accept_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> in_valid_reg)
        else $error("accepted beat lost");

    // A beat moving forward always shows up on the output.
    a_move_out: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_adv |=> m_tvalid)
        else $error("beat lost between stages");

    // With nothing behind it, a drained output beat leaves the output empty.
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !in_valid_reg |=> !m_tvalid)
        else $error("beat repeated on output");
`endif

endmodule
